@@ src/match_endpoint_error_precision_unit_assert.svh @@
// Assertion macros used by the checker file.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef MATCH_ENDPOINT_ERROR_PRECISION_UNIT_ASSERT_SVH
`define MATCH_ENDPOINT_ERROR_PRECISION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MEPU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define MEPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ src/mepu_pkg.sv @@
`default_nettype none

package mepu_pkg;

  // Clamp limits for the image dimensions in use.
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;

  localparam int unsigned CountBitsDef = 20;

  // Precision scale and the quotient bits it needs.
  localparam int unsigned Permyriad = 10000;
  localparam int unsigned PrecBits  = $clog2(Permyriad + 1);

  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdMatch = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgInlierRadius = 2'd2
  } cfg_idx_e;

  // One classified item on its way from front to back.
  typedef struct packed {
    cmd_e               cmd;
    logic [15:0]        addr;
    logic [31:0]        truth;     // {truth_v, truth_u}
    logic signed [13:0] disp_u;    // integer displacement
    logic signed [13:0] disp_v;
    logic               in_bounds;
    logic               last;
  } entry_t;

endpackage

`default_nettype wire

@@ src/mepu_front.sv @@
`default_nettype none

module mepu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [15:0]          pixel_index_i,
  input  logic signed [15:0]   truth_u_i,
  input  logic signed [15:0]   truth_v_i,
  input  logic signed [16:0]   src_x_i,
  input  logic signed [16:0]   src_y_i,
  input  logic signed [16:0]   dst_x_i,
  input  logic signed [16:0]   dst_y_i,
  input  logic                 last_match_i,
  input  logic [8:0]           image_width_i,
  input  logic [8:0]           image_height_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output mepu_pkg::entry_t     push_entry_o
);
  import mepu_pkg::*;

  function automatic logic [8:0] clamp_dim(input logic [8:0] v, input int unsigned maxv);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (int'(v) > int'(maxv)) begin
      r = 9'(maxv);
    end
    return r;
  endfunction

  logic [8:0]         w, h;
  logic [16:0]        tx, ty;
  logic signed [12:0] px, py;
  logic signed [17:0] dsp_x, dsp_y;
  logic [17:0]        tdx, tdy;
  logic               inb;
  logic [20:0]        lin;
  entry_t             cls;
  entry_t             stage_q;
  logic               stage_valid_q, stage_valid_d;
  logic               accept;

  assign w = clamp_dim(image_width_i, MaxWidth);
  assign h = clamp_dim(image_height_i, MaxHeight);

  // Truncate toward zero: bias negatives by 15 before the shift.
  assign tx = src_x_i + {13'd0, {4{src_x_i[16]}}};
  assign ty = src_y_i + {13'd0, {4{src_y_i[16]}}};
  assign px = tx[16:4];
  assign py = ty[16:4];

  assign dsp_x = 18'(dst_x_i) - 18'(src_x_i);
  assign dsp_y = 18'(dst_y_i) - 18'(src_y_i);
  assign tdx   = dsp_x + {14'd0, {4{dsp_x[17]}}};
  assign tdy   = dsp_y + {14'd0, {4{dsp_y[17]}}};

  assign inb = !px[12] && !py[12] && (px[11:0] < 12'(w)) && (py[11:0] < 12'(h));
  assign lin = 21'(py[11:0]) * 21'(w) + 21'(px[11:0]);

  always_comb begin
    cls.cmd       = cmd_e'(command_i);
    cls.truth     = {truth_v_i, truth_u_i};
    cls.disp_u    = tdx[17:4];
    cls.disp_v    = tdy[17:4];
    cls.in_bounds = inb;
    cls.last      = last_match_i;
    if (cmd_e'(command_i) == CmdWrite) begin
      cls.addr = pixel_index_i;
    end else begin
      cls.addr = lin[15:0];
    end
  end

  assign in_ready_o    = !stage_valid_q || push_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign stage_valid_d = accept || (stage_valid_q && !push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= cls;
    end
  end

  assign push_valid_o = stage_valid_q;
  assign push_entry_o = stage_q;

endmodule

`default_nettype wire

@@ src/mepu_queue.sv @@
`default_nettype none

module mepu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mepu_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mepu_pkg::entry_t pop_entry_o
);
  import mepu_pkg::*;

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  entry_t               slots_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != CntBits'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ src/mepu_back.sv @@
`default_nettype none

module mepu_back #(
  parameter int unsigned COUNT_BITS = mepu_pkg::CountBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  mepu_pkg::entry_t q_entry_i,
  input  logic [7:0]       inlier_radius_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [19:0]      inlier_count_o,
  output logic [19:0]      match_count_o,
  output logic [13:0]      precision_permyriad_o
);
  import mepu_pkg::*;

  localparam int unsigned NumBits  = COUNT_BITS + PrecBits;
  localparam int unsigned StepBits = $clog2(PrecBits);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StErr  = 6'b000010,
    StCmp  = 6'b000100,
    StMul  = 6'b001000,
    StDiv  = 6'b010000,
    StOut  = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;

  logic [31:0]           store_mem [StoreDepth];
  logic [31:0]           rd_q;
  logic                  st_we, st_re;

  logic signed [13:0]    cur_u_q, cur_v_q;
  logic                  cur_inb_q, cur_last_q;

  logic signed [17:0]    u16, v16;
  logic signed [15:0]    gu, gv;
  logic signed [18:0]    eu, ev;
  logic [17:0]           mag_u, mag_v;
  logic [35:0]           sq_u_q, sq_v_q;
  logic [36:0]           err2;
  logic [23:0]           lim;
  logic                  hit;

  logic [COUNT_BITS-1:0] inl_cnt_q, inl_cnt_d, mat_cnt_q, mat_cnt_d;
  logic [COUNT_BITS-1:0] inl_new, mat_new;
  logic [COUNT_BITS-1:0] res_inl_q, res_mat_q;

  logic [NumBits-1:0]    prod;
  logic [COUNT_BITS-1:0] rem_q, rem_nx;
  logic [PrecBits-1:0]   low_q, low_nx;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  ge;
  logic [StepBits-1:0]   step_q, step_d;

  logic                  out_valid_q, out_valid_d, load_out;
  logic [19:0]           out_inl_q, out_mat_q;
  logic [13:0]           out_prec_q;

  // Endpoint error against the stored truth, both axes.
  assign u16   = {cur_u_q, 4'b0000};
  assign v16   = {cur_v_q, 4'b0000};
  assign gu    = rd_q[15:0];
  assign gv    = rd_q[31:16];
  assign eu    = 19'(u16) - 19'(gu);
  assign ev    = 19'(v16) - 19'(gv);
  assign mag_u = eu[18] ? 18'(-eu) : 18'(eu);
  assign mag_v = ev[18] ? 18'(-ev) : 18'(ev);

  assign err2 = 37'(sq_u_q) + 37'(sq_v_q);
  assign lim  = {16'(inlier_radius_i) * 16'(inlier_radius_i), 8'd0};
  assign hit  = cur_inb_q && (err2 <= 37'(lim));

  assign mat_new = (mat_cnt_q == '1) ? mat_cnt_q : mat_cnt_q + 1'b1;
  assign inl_new = (hit && (inl_cnt_q != '1)) ? inl_cnt_q + 1'b1 : inl_cnt_q;

  assign prod = NumBits'(res_inl_q) * NumBits'(Permyriad);

  // Restoring divide, one quotient bit per cycle.
  assign trial  = {rem_q, low_q[PrecBits-1]};
  assign diff   = trial - {1'b0, res_mat_q};
  assign ge     = (trial >= {1'b0, res_mat_q});
  assign rem_nx = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign low_nx = {low_q[PrecBits-2:0], ge};

  always_comb begin
    state_d   = state_q;
    q_ready_o = 1'b0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    load_out  = 1'b0;
    inl_cnt_d = inl_cnt_q;
    mat_cnt_d = mat_cnt_q;
    step_d    = step_q;
    case (state_q)
      StIdle: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_entry_i.cmd == CmdWrite) begin
            st_we = 1'b1;
          end else begin
            st_re   = 1'b1;
            state_d = StErr;
          end
        end
      end
      StErr: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (cur_last_q) begin
          inl_cnt_d = '0;
          mat_cnt_d = '0;
          state_d   = StMul;
        end else begin
          inl_cnt_d = inl_new;
          mat_cnt_d = mat_new;
          state_d   = StIdle;
        end
      end
      StMul: begin
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        step_d = step_q + 1'b1;
        if (step_q == StepBits'(PrecBits - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      inl_cnt_q   <= '0;
      mat_cnt_q   <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inl_cnt_q   <= inl_cnt_d;
      mat_cnt_q   <= mat_cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Truth store: one port, registered read.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[q_entry_i.addr] <= q_entry_i.truth;
    end
    if (st_re) begin
      rd_q <= store_mem[q_entry_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_re) begin
      cur_u_q    <= q_entry_i.disp_u;
      cur_v_q    <= q_entry_i.disp_v;
      cur_inb_q  <= q_entry_i.in_bounds;
      cur_last_q <= q_entry_i.last;
    end
    if (state_q == StErr) begin
      sq_u_q <= mag_u * mag_u;
      sq_v_q <= mag_v * mag_v;
    end
    if ((state_q == StCmp) && cur_last_q) begin
      res_inl_q <= inl_new;
      res_mat_q <= mat_new;
    end
    if (state_q == StMul) begin
      rem_q <= prod[NumBits-1:PrecBits];
      low_q <= prod[PrecBits-1:0];
    end else if (state_q == StDiv) begin
      rem_q <= rem_nx;
      low_q <= low_nx;
    end
    if (load_out) begin
      out_inl_q  <= 20'(res_inl_q);
      out_mat_q  <= 20'(res_mat_q);
      out_prec_q <= (res_mat_q == '0) ? 14'd0 : 14'(low_q);
    end
  end

  assign out_valid_o           = out_valid_q;
  assign inlier_count_o        = out_inl_q;
  assign match_count_o         = out_mat_q;
  assign precision_permyriad_o = out_prec_q;

endmodule

`default_nettype wire

@@ src/match_endpoint_error_precision_unit.sv @@
// Channel   Handshake                    Payload
// --------  ---------------------------  ------------------------------------------------
// in        in_valid_i / in_ready_o      command, pixel_index, truth_u/v, src/dst x/y, last
// out       out_valid_o / out_ready_i    inlier_count, match_count, precision_permyriad
// cfg       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i (always ready)
//
// Sequence: the back end takes a truth write in its idle state; a match goes through
//   the store read, the squared error and the compare and count; a last match adds
//   the multiply, a 14-step bit-per-cycle divide and the output load. The single-port
//   truth store and the shared back-end sequencer set this sequence.
// Reset: clears counters, queue and handshakes; the truth store is not cleared and
//   holds garbage until written, so no clearing pass runs after reset.
// Stalls: a register stage and a two-entry queue sit between front and back, and the
//   result sits in an output register, so input transfers keep going while a result
//   waits until the queue fills.
`default_nettype none

module match_endpoint_error_precision_unit #(
  parameter int unsigned COUNT_BITS = mepu_pkg::CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [15:0]        pixel_index_i,
  input  logic signed [15:0] truth_u_i,
  input  logic signed [15:0] truth_v_i,
  input  logic signed [16:0] src_x_i,
  input  logic signed [16:0] src_y_i,
  input  logic signed [16:0] dst_x_i,
  input  logic signed [16:0] dst_y_i,
  input  logic               last_match_i,
  // Result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [19:0]        inlier_count_o,
  output logic [19:0]        match_count_o,
  output logic [13:0]        precision_permyriad_o,
  // Register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  import mepu_pkg::*;

  logic [8:0] image_width_q, image_height_q;
  logic [7:0] inlier_radius_q;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  entry_t     push_entry, pop_entry;

  // Registers are to be written only while the datapath is idle; the block does not enforce this, so no shadowing.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 9'd256;
      image_height_q  <= 9'd256;
      inlier_radius_q <= 8'd5;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgImageWidth:   image_width_q   <= cfg_data_i;
        CfgImageHeight:  image_height_q  <= cfg_data_i;
        CfgInlierRadius: inlier_radius_q <= cfg_data_i[7:0];
        default: begin
          // Unknown index: drop the write.
        end
      endcase
    end
  end

  // Front: take the transfer, truncate coordinates, test bounds, form the address.
  mepu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .pixel_index_i  (pixel_index_i),
    .truth_u_i      (truth_u_i),
    .truth_v_i      (truth_v_i),
    .src_x_i        (src_x_i),
    .src_y_i        (src_y_i),
    .dst_x_i        (dst_x_i),
    .dst_y_i        (dst_y_i),
    .last_match_i   (last_match_i),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_entry_o   (push_entry)
  );

  // Short queue decoupling the two halves.
  mepu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Back: truth store, error test, counters and the precision divider.
  mepu_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_valid_i             (pop_valid),
    .q_ready_o             (pop_ready),
    .q_entry_i             (pop_entry),
    .inlier_radius_i       (inlier_radius_q),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .inlier_count_o        (inlier_count_o),
    .match_count_o         (match_count_o),
    .precision_permyriad_o (precision_permyriad_o)
  );

endmodule

`default_nettype wire

@@ src/mepu_checker.sv @@
`default_nettype none
`include "match_endpoint_error_precision_unit_assert.svh"

module mepu_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [19:0]        inlier_count_o,
  input wire logic [19:0]        match_count_o,
  input wire logic [13:0]        precision_permyriad_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o
);
  import mepu_pkg::*;

  // A waiting result holds until its transfer.
  `MEPU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(inlier_count_o) && $stable(match_count_o) && $stable(precision_permyriad_o))

  // Precision never exceeds the full scale.
  `MEPU_ASSERT_IMPL(a_prec_range, out_valid_o, precision_permyriad_o <= 14'(Permyriad))

  // Full scale only when every match was an inlier.
  `MEPU_ASSERT_IMPL(a_full_scale, out_valid_o && (precision_permyriad_o == 14'(Permyriad)), inlier_count_o == match_count_o)

  // Input ready is always a clean level while an item is offered.
  `MEPU_ASSERT_IMPL(a_in_ready_known, in_valid_i, !$isunknown(in_ready_o))

  // Register writes never stall.
  `MEPU_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind match_endpoint_error_precision_unit mepu_checker u_mepu_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_ready_o            (in_ready_o),
  .out_valid_o           (out_valid_o),
  .out_ready_i           (out_ready_i),
  .inlier_count_o        (inlier_count_o),
  .match_count_o         (match_count_o),
  .precision_permyriad_o (precision_permyriad_o),
  .cfg_valid_i           (cfg_valid_i),
  .cfg_ready_o           (cfg_ready_o)
);

`default_nettype wire

@@ tb/tb_match_endpoint_error_precision_unit.sv @@
`timescale 1ns / 100ps

module tb_match_endpoint_error_precision_unit;
  import mepu_pkg::*;

  // Settle time after the last expected result: two queue entries, the register
  // stage and the back end (its match steps, then the closing multiply and divide).
  localparam int     DrainCycles = 64;
  localparam int     RandomItems = 600;
  localparam longint CountMax    = 64'hFFFFF;

  typedef logic signed [16:0] coord_t;
  typedef logic signed [15:0] flow_t;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] pix;
    flow_t       tu;
    flow_t       tv;
    coord_t      sx;
    coord_t      sy;
    coord_t      dx;
    coord_t      dy;
    logic        last;
  } flow_item_t;

  typedef struct packed {
    logic [19:0] inlier_total;
    logic [19:0] match_total;
    logic [13:0] permyriad;
  } score_t;

  typedef enum {PickNear, PickWild, PickOutside, PickNoise} match_pick_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               command_i     = 1'b0;
  logic [15:0]        pixel_index_i = '0;
  logic signed [15:0] truth_u_i     = '0;
  logic signed [15:0] truth_v_i     = '0;
  logic signed [16:0] src_x_i       = '0;
  logic signed [16:0] src_y_i       = '0;
  logic signed [16:0] dst_x_i       = '0;
  logic signed [16:0] dst_y_i       = '0;
  logic               last_match_i  = 1'b0;

  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [19:0]        inlier_count_o;
  logic [19:0]        match_count_o;
  logic [13:0]        precision_permyriad_o;

  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i   = '0;
  logic [8:0]         cfg_data_i    = '0;

  // Local copy of the block's state: truth store, which entries hold data,
  // register values as written and the running counts of the open set.
  logic [31:0] truth_flow  [StoreDepth];
  bit          truth_known [StoreDepth];
  logic [8:0]  cur_width  = 9'd256;
  logic [8:0]  cur_height = 9'd256;
  logic [7:0]  cur_radius = 8'd5;
  longint      run_inliers = 0;
  longint      run_matches = 0;
  score_t      score_q[$];

  int errors      = 0;
  int items_sent  = 0;
  int burst_left  = 0;

  logic [15:0] stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  match_endpoint_error_precision_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .command_i             (command_i),
    .pixel_index_i         (pixel_index_i),
    .truth_u_i             (truth_u_i),
    .truth_v_i             (truth_v_i),
    .src_x_i               (src_x_i),
    .src_y_i               (src_y_i),
    .dst_x_i               (dst_x_i),
    .dst_y_i               (dst_y_i),
    .last_match_i          (last_match_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .inlier_count_o        (inlier_count_o),
    .match_count_o         (match_count_o),
    .precision_permyriad_o (precision_permyriad_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Small helpers
  // ---------------------------------------------------------------------------

  function automatic longint rand_between(longint lo, longint hi);
    return lo + longint'($urandom_range(0, hi - lo));
  endfunction

  // Zero acts as one, anything past the maximum acts as the maximum.
  function automatic longint dim_in_use(logic [8:0] v, longint maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint sat_count(longint c);
    return (c < CountMax) ? c + 1 : CountMax;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // Truncate the source toward zero; return whether it lands in the image
  // and the row-major store address it reads.
  function automatic bit src_pixel(coord_t sx, coord_t sy, output logic [15:0] addr);
    longint w, h, x, y;
    w = dim_in_use(cur_width, MaxWidth);
    h = dim_in_use(cur_height, MaxHeight);
    x = longint'(sx) / 16;
    y = longint'(sy) / 16;
    addr = y * w + x;
    return (x >= 0 && x < w && y >= 0 && y < h);
  endfunction

  // Mostly modest flow so that near matches stay within reach of the radius,
  // now and then anything the field can hold.
  function automatic flow_t random_flow();
    if ($urandom_range(0, 3) == 0) return rand_between(-32768, 32767);
    return rand_between(-640, 640);
  endfunction

  function automatic logic [8:0] random_dim();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd256;
      2: return rand_between(257, 511);
      default: return rand_between(1, 24);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Score predictor: advance the local state by one accepted item and queue
  // the score it closes, if any.
  // ---------------------------------------------------------------------------
  function automatic void score_item(flow_item_t it);
    logic [15:0] a;
    logic [31:0] e;
    longint      u, v, eu, ev, err2, lim;
    score_t      s;
    if (it.cmd == CmdWrite) begin
      // last_match on a write has no effect
      truth_flow[it.pix]  = {it.tv, it.tu};
      truth_known[it.pix] = 1'b1;
      return;
    end
    run_matches = sat_count(run_matches);
    if (src_pixel(it.sx, it.sy, a)) begin
      e  = truth_flow[a];
      // integer displacement, truncated toward zero, back in 1/16 pixel units
      u  = (longint'(it.dx) - longint'(it.sx)) / 16;
      v  = (longint'(it.dy) - longint'(it.sy)) / 16;
      eu = u * 16 - longint'($signed(e[15:0]));
      ev = v * 16 - longint'($signed(e[31:16]));
      err2 = eu * eu + ev * ev;
      lim  = longint'(cur_radius) * longint'(cur_radius) * 256;
      if (err2 <= lim) run_inliers = sat_count(run_inliers);
    end
    if (it.last) begin
      s.inlier_total = run_inliers;
      s.match_total  = run_matches;
      s.permyriad    = (run_matches != 0) ? run_inliers * Permyriad / run_matches : 0;
      score_q.push_back(s);
      run_inliers = 0;
      run_matches = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one item. The sender runs in bursts; between bursts drop valid for a
  // random gap, mostly short, sometimes long. A gap of zero keeps valid high.
  task automatic send_item(flow_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
    end
    in_valid_i    <= 1'b1;
    command_i     <= it.cmd;
    pixel_index_i <= it.pix;
    truth_u_i     <= it.tu;
    truth_v_i     <= it.tv;
    src_x_i       <= it.sx;
    src_y_i       <= it.sy;
    dst_x_i       <= it.dx;
    dst_y_i       <= it.dy;
    last_match_i  <= it.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    score_item(it);
    burst_left--;
  endtask

  // Ground-truth write; the match-only fields carry noise.
  task automatic send_write(logic [15:0] pix, flow_t tu, flow_t tv);
    flow_item_t it;
    it.cmd  = CmdWrite;
    it.pix  = pix;
    it.tu   = tu;
    it.tv   = tv;
    it.sx   = rand_between(-65536, 65535);
    it.sy   = rand_between(-65536, 65535);
    it.dx   = rand_between(-65536, 65535);
    it.dy   = rand_between(-65536, 65535);
    it.last = $urandom_range(0, 1);
    send_item(it);
  endtask

  // Never let a match read a store entry that holds nothing yet: write it first.
  task automatic fill_pixel(coord_t sx, coord_t sy, output logic [15:0] a);
    if (src_pixel(sx, sy, a) && !truth_known[a]) send_write(a, random_flow(), random_flow());
  endtask

  task automatic send_match(coord_t sx, coord_t sy, coord_t dx, coord_t dy, logic last);
    flow_item_t  it;
    logic [15:0] a;
    fill_pixel(sx, sy, a);
    it.cmd  = CmdMatch;
    it.pix  = $urandom_range(0, 65535);
    it.tu   = rand_between(-32768, 32767);
    it.tv   = rand_between(-32768, 32767);
    it.sx   = sx;
    it.sy   = sy;
    it.dx   = dx;
    it.dy   = dy;
    it.last = last;
    send_item(it);
  endtask

  task automatic send_random_match(logic last);
    longint      w, h, sx, sy, dx, dy, reach;
    int          r;
    logic [15:0] a;
    logic [31:0] e;
    match_pick_e pick;
    w = dim_in_use(cur_width, MaxWidth);
    h = dim_in_use(cur_height, MaxHeight);
    r = $urandom_range(0, 9);
    pick = (r < 5) ? PickNear : (r < 7) ? PickWild : (r < 9) ? PickOutside : PickNoise;
    // Start from a source inside the image; near column or row zero, sometimes
    // use a small negative coordinate that still truncates to zero.
    sx = rand_between(0, w - 1) * 16 + rand_between(0, 15);
    sy = rand_between(0, h - 1) * 16 + rand_between(0, 15);
    if (sx < 16 && $urandom_range(0, 2) == 0) sx = -rand_between(1, 15);
    if (sy < 16 && $urandom_range(0, 2) == 0) sy = -rand_between(1, 15);
    dx = rand_between(-65536, 65535);
    dy = rand_between(-65536, 65535);
    case (pick)
      PickNear: begin
        // aim at the stored truth, off by up to a bit more than the radius
        fill_pixel(clamp_coord(sx), clamp_coord(sy), a);
        e     = truth_flow[a];
        reach = longint'(cur_radius) * 16 + 24;
        dx = sx + longint'($signed(e[15:0])) + rand_between(-reach, reach);
        dy = sy + longint'($signed(e[31:16])) + rand_between(-reach, reach);
      end
      PickWild: ;
      PickOutside: begin
        case ($urandom_range(0, 3))
          0: sx = rand_between(-65536, -16);
          1: sx = rand_between(w * 16, 65535);
          2: sy = rand_between(-65536, -16);
          default: sy = rand_between(h * 16, 65535);
        endcase
      end
      PickNoise: begin
        sx = rand_between(-65536, 65535);
        sy = rand_between(-65536, 65535);
      end
    endcase
    send_match(clamp_coord(sx), clamp_coord(sy), clamp_coord(dx), clamp_coord(dy), last);
  endtask

  // Hold the input idle until every queued score has come back, then let the
  // back end finish whatever non-scoring work is still in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes, only issued while the block is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgImageWidth:   cur_width  = data;
      CfgImageHeight:  cur_height = data;
      CfgInlierRadius: cur_radius = data[7:0];
      default: ;
    endcase
  endtask

  // Write all three registers back to back; the radius takes a random
  // unused top bit, which must be ignored.
  task automatic set_config(logic [8:0] w, logic [8:0] h, logic [7:0] r);
    write_reg(CfgImageWidth, w);
    write_reg(CfgImageHeight, h);
    write_reg(CfgInlierRadius, {1'($urandom_range(0, 1)), r});
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall on a pattern of its own and check each transfer
  // ---------------------------------------------------------------------------
  task automatic report(string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_score();
    score_t want;
    if (score_q.size() == 0) begin
      report($sformatf("score %0d/%0d/%0d with none pending",
                       inlier_count_o, match_count_o, precision_permyriad_o));
      return;
    end
    want = score_q.pop_front();
    if (inlier_count_o !== want.inlier_total)
      report($sformatf("inlier_count %0d, want %0d", inlier_count_o, want.inlier_total));
    if (match_count_o !== want.match_total)
      report($sformatf("match_count %0d, want %0d", match_count_o, want.match_total));
    if (precision_permyriad_o !== want.permyriad)
      report($sformatf("precision_permyriad %0d, want %0d",
                       precision_permyriad_o, want.permyriad));
  endtask

  // When the low six bits of stall_tick are zero, pick a new stall mode: always
  // ready, mostly ready, mostly stalled, or following bit 3 of stall_tick.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_score();
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[5:0] == 0) stall_mode <= $urandom_range(0, 3);
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= stall_tick[3];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers (256 x 256, radius 5) with the field
  // extremes: saturated truth, full-range targets, corner pixels, negative
  // fractions that truncate to pixel zero, sources off the left, right and bottom
  // edges, the exact radius boundary, and last_match on a write.
  task automatic test_reset_defaults();
    send_write(16'd0, 16'sh7FFF, -16'sd32768);
    send_write(16'hFFFF, 16'sd0, 16'sd0);
    send_write(16'd1, 16'sd48, -16'sd32);
    send_match(17'sd0, 17'sd0, 17'sd32767, -17'sd32768, 1'b0);
    send_match(-17'sd15, -17'sd15, -17'sd65536, 17'sd65535, 1'b0);
    send_match(17'sd4095, 17'sd4095, 17'sd4095, 17'sd4095, 1'b0);
    send_match(17'sd65535, 17'sd65535, 17'sd0, 17'sd0, 1'b0);
    send_match(-17'sd65536, 17'sd0, 17'sd0, 17'sd0, 1'b0);
    send_match(17'sd4096, 17'sd0, 17'sd4096, 17'sd0, 1'b0);
    send_match(17'sd16, 17'sd0, 17'sd64, -17'sd32, 1'b1);
    // one-match sets: nothing in range, then a clean hit
    send_match(-17'sd16, 17'sd0, 17'sd0, 17'sd0, 1'b1);
    send_write(16'd2, 16'sd0, 16'sd0);
    send_match(17'sd32, 17'sd0, 17'sd32, 17'sd0, 1'b1);
    // error of exactly five pixels, one sixteenth past it, and a negative
    // displacement that truncates toward zero
    send_write(16'd3, -16'sd1, 16'sd0);
    send_match(17'sd32, 17'sd0, 17'sd112, 17'sd0, 1'b0);
    send_match(17'sd48, 17'sd0, 17'sd128, 17'sd0, 1'b0);
    send_match(17'sd48, 17'sd0, 17'sd31, 17'sd0, 1'b1);
    wait_idle();
  endtask

  // Zero width and height act as one, oversize ones as the maximum; radius
  // at both ends.
  task automatic test_dimension_clamp();
    set_config(9'd0, 9'd0, 8'd0);
    send_match(17'sd15, 17'sd15, 17'sd15, 17'sd15, 1'b0);
    send_match(17'sd16, 17'sd0, 17'sd16, 17'sd0, 1'b0);
    send_match(17'sd0, 17'sd16, 17'sd0, 17'sd16, 1'b1);
    wait_idle();
    set_config(9'd511, 9'd511, 8'd255);
    send_match(17'sd4095, 17'sd4095, 17'sd7295, 17'sd4095, 1'b0);
    send_match(17'sd4095, 17'sd4095, 17'sd8895, 17'sd4095, 1'b0);
    send_match(17'sd4096, 17'sd0, 17'sd4096, 17'sd0, 1'b1);
    wait_idle();
    set_config(9'd300, 9'd2, 8'd1);
    send_match(17'sd4080, 17'sd16, 17'sd4080, 17'sd16, 1'b0);
    send_match(17'sd0, 17'sd32, 17'sd0, 17'sd32, 1'b1);
    wait_idle();
  endtask

  // Phases of random register settings, each a few sets of random matches
  // with stray and repeated truth writes mixed in; drain between phases.
  task automatic test_random_sets();
    int          sets, len;
    logic [7:0]  r;
    logic [15:0] pix;
    while (items_sent < RandomItems) begin
      case ($urandom_range(0, 5))
        0:       r = 8'd255;
        1:       r = $urandom_range(0, 255);
        default: r = $urandom_range(0, 8);
      endcase
      set_config(random_dim(), random_dim(), r);
      sets = $urandom_range(1, 4);
      repeat (sets) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            // either rewrite a pixel of the image or land anywhere in the store
            if ($urandom_range(0, 1) == 0)
              pix = rand_between(0, dim_in_use(cur_height, MaxHeight) - 1) *
                    dim_in_use(cur_width, MaxWidth) +
                    rand_between(0, dim_in_use(cur_width, MaxWidth) - 1);
            else
              pix = $urandom_range(0, 65535);
            send_write(pix, random_flow(), random_flow());
            items_sent++;
          end
          send_random_match(i == len - 1);
          items_sent++;
        end
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_dimension_clamp();
    test_random_sets();
    wait_idle();
    if (errors == 0) begin
      $display("tb_match_endpoint_error_precision_unit OK");
    end else begin
      $display("tb_match_endpoint_error_precision_unit NOT OK");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("tb_match_endpoint_error_precision_unit NOT OK");
    $finish;
  end

endmodule
